FILE: rtl/dvf_pkg.sv
package dvf_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 64;
  localparam int OCC_W       = 2;

  localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(2);

  // Input command codes.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_FLUSH,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // load the key and restart the table scan
    logic scan;    // run the scan pipeline
    logic flush;   // the scan is a flush report
    logic hit_wr;  // raise the count of the entry that matched
    logic append;  // append the key, or mark overflow when full
    logic finish;  // close the report and clear the table
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // entry in the compare stage equals the key
    logic done;      // every used entry has passed the compare stage
    logic out_busy;  // output register holds an item that is not taken
  } dp_sts_t;

endpackage

FILE: rtl/duplicate_value_finder.sv
// Duplicate value finder. The block keeps a table of up to TABLE_DEPTH distinct
// signed 64-bit values in first-seen order, each with an occurrence count that
// saturates at two. An add item (cmd 0) produces no output: it scans the table,
// raises the count of a matching entry, or appends the value with count one;
// when the table is full a new value is dropped and the overflow flag is set.
// A flush item (cmd 1) reports every value seen more than once, in first-seen
// order, with last set on the final one, or a single item with has_value low
// when there are none; every item of the report carries the overflow flag, and
// the table and flag are then cleared. The table is held in a memory with one
// registered read port, so the scan compares one entry per cycle, save where a
// flush scan is held while the output waits for out_ready: an add item
// occupies the block until it finds a match or has passed every entry in use,
// and a flush item until the scan has passed every entry in use and the final
// item is loaded into the output register. Items are taken one at a time;
// in_ready is high only while the block is idle, but the output register lets
// a new item be accepted while the last report item still waits to be taken.
module duplicate_value_finder
  import dvf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] dup_value,
  output logic                    has_value,
  output logic                    overflowed,
  output logic                    last
);

  // Command and status between the sequencer and the table datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The controller steps through idle, add scan, flush scan and report close.
  dvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts)
  );

  // The datapath holds the table memories, the scan pipeline, the pending
  // duplicate and the output register.
  dvf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .dup_value  (dup_value),
    .has_value  (has_value),
    .overflowed (overflowed),
    .last       (last)
  );

endmodule

FILE: rtl/dvf_datapath.sv
module dvf_datapath
  import dvf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 dp_cmd,
  output dp_sts_t                 dp_sts,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] dup_value,
  output logic                    has_value,
  output logic                    overflowed,
  output logic                    last
);

  logic [VAL_W-1:0] value_mem [TABLE_DEPTH];
  logic [OCC_W-1:0] count_mem [TABLE_DEPTH];

  logic [CNT_W-1:0] used;
  logic             ovf;
  logic [CNT_W-1:0] iss_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [VAL_W-1:0] rd_val;
  logic [OCC_W-1:0] rd_cnt;
  logic [VAL_W-1:0] key;
  logic             pend_vld;
  logic [VAL_W-1:0] pend_val;

  logic dup_now;
  logic out_busy;
  logic adv;
  logic rd_en;
  logic emit_mid;
  logic close_now;
  logic load_out;
  logic table_full;

  assign out_busy   = out_valid && !out_ready;
  assign dup_now    = rd_vld && (rd_cnt == OCC_MAX);
  // A second duplicate found while the first still waits for the output
  // register holds the whole scan pipeline.
  assign adv        = !(dp_cmd.flush && dup_now && pend_vld && out_busy);
  assign rd_en      = dp_cmd.scan && adv && (iss_idx < used);
  assign emit_mid   = dp_cmd.scan && dp_cmd.flush && dup_now && adv;
  assign close_now  = dp_cmd.finish && !out_busy;
  assign load_out   = (emit_mid && pend_vld) || close_now;
  assign table_full = (used == CNT_W'(TABLE_DEPTH));

  assign dp_sts.hit      = rd_vld && (rd_val == key);
  assign dp_sts.done     = !rd_vld && (iss_idx == used);
  assign dp_sts.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      ovf       <= 1'b0;
      iss_idx   <= '0;
      rd_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (dp_cmd.start) begin
        iss_idx  <= '0;
        rd_vld   <= 1'b0;
        pend_vld <= 1'b0;
      end else if (dp_cmd.scan && adv) begin
        rd_vld <= rd_en;
        if (rd_en) begin
          iss_idx <= iss_idx + CNT_W'(1);
        end
        if (emit_mid) begin
          pend_vld <= 1'b1;
        end
      end
      if (dp_cmd.append) begin
        if (table_full) begin
          ovf <= 1'b1;
        end else begin
          used <= used + CNT_W'(1);
        end
      end
      if (close_now) begin
        used     <= '0;
        ovf      <= 1'b0;
        pend_vld <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Table memories: one read port for the scan, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_val <= value_mem[iss_idx[IDX_W-1:0]];
      rd_cnt <= count_mem[iss_idx[IDX_W-1:0]];
      rd_idx <= iss_idx[IDX_W-1:0];
    end
    if (dp_cmd.hit_wr) begin
      count_mem[rd_idx] <= (rd_cnt == OCC_MAX) ? OCC_MAX : rd_cnt + OCC_W'(1);
    end else if (dp_cmd.append && !table_full) begin
      value_mem[used[IDX_W-1:0]] <= key;
      count_mem[used[IDX_W-1:0]] <= OCC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.start) begin
      key <= value;
    end
    if (emit_mid) begin
      pend_val <= rd_val;
    end
    if (load_out) begin
      overflowed <= ovf;
      if (close_now) begin
        dup_value <= pend_vld ? pend_val : '0;
        has_value <= pend_vld;
        last      <= 1'b1;
      end else begin
        dup_value <= pend_val;
        has_value <= 1'b1;
        last      <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CNT_W'(rd_idx) < used))
    else $error("Scan reads an entry beyond the used part of the table.");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    close_now |=> (used == '0) && !ovf && out_valid && last)
    else $error("Closing a report did not clear the table.");
`endif

endmodule

FILE: rtl/dvf_ctrl.sv
module dvf_ctrl
  import dvf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cmd,
  output dp_cmd_t dp_cmd,
  input  dp_sts_t dp_sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.start = 1'b1;
          state_next   = (cmd == CMD_FLUSH) ? S_FLUSH : S_ADD;
        end
      end
      S_ADD: begin
        dp_cmd.scan = 1'b1;
        if (dp_sts.hit) begin
          dp_cmd.hit_wr = 1'b1;
          state_next    = S_IDLE;
        end else if (dp_sts.done) begin
          dp_cmd.append = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FLUSH: begin
        dp_cmd.scan  = 1'b1;
        dp_cmd.flush = 1'b1;
        if (dp_sts.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        dp_cmd.finish = 1'b1;
        if (!dp_sts.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_hit_ends_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) && dp_sts.hit |=> (state == S_IDLE))
    else $error("A matching entry did not end the add.");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> !dp_cmd.hit_wr && !dp_cmd.append)
    else $error("Table written during a flush report.");
`endif

endmodule
